>>> hdl/sha_pkg.sv
// SHA-256 stream hasher package: payload types, state enum, round constants and the IV.
// No dependencies.
`default_nettype none
package sha_pkg;
   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
      logic        zero_digest_error;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_FILL, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
   } state_type;

   localparam int BUF_DEPTH = 64;
   localparam int SCHED_DEPTH = 16;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
   endfunction

   function automatic logic [31:0] init_value(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[i];
   endfunction
endpackage
`default_nettype wire

>>> hdl/sha_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module sha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> hdl/sha_round.sv
// One SHA-256 round: message schedule word and working-variable update.
// Depends on sha_pkg.
`default_nettype none
module sha_round (
   input  wire logic [5:0]  t,
   input  wire logic [31:0] w_direct,
   input  wire logic [31:0] w16,
   input  wire logic [31:0] w15,
   input  wire logic [31:0] w7,
   input  wire logic [31:0] w2,
   input  wire logic [255:0] v_in,
   output logic      [31:0] w_out,
   output logic      [255:0] v_out
);
   import sha_pkg::*;

   logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;

   always_comb begin
      {a, b, c, d, e, f, g, h} = v_in;
      s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
      s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
      w_out = (t < 6'd16) ? w_direct : w16 + s0 + w7 + s1;
      t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
         + ((e & f) ^ (~e & g)) + round_k(t) + w_out;
      t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
         + ((a & b) ^ (a & c) ^ (b & c));
      v_out = {t1 + t2, a, b, c, d + t1, e, f, g};
   end
endmodule
`default_nettype wire

>>> hdl/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher top level: control sequencer, block buffer RAM, schedule window.
// Depends on sha_pkg, sha_ram and sha_round.
`default_nettype none
// A message byte is one req transaction; the 64th byte of a block starts a
// compression: 64 loads of bytes from the block RAM (its single read port, registered
// read), 64 rounds, then a fold of the chaining value, so a full block stalls req
// until the fold is done. A finish transaction pads into the same RAM one byte a cycle,
// runs one or two compressions and then sends eight rsp transactions, H0 first, one per
// cycle while rsp_stall is low. The schedule is kept as a 16-word shift window in
// registers. No clearing pass after reset.
module sha256_stream_hasher_unit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire sha_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output sha_pkg::rsp_payload_type      rsp_payload
);
   import sha_pkg::*;

   state_type state_ff, state_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  bytes_ff, bytes_in;
   logic [255:0] hash_ff, hash_in, v_ff, v_in;
   logic [31:0]  win_ff [SCHED_DEPTH];
   logic [31:0]  pack_ff, pack_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         first_ff, first_in, finish_ff, finish_in, zero_ff, zero_in;
   logic         lenpad_ff, lenpad_in;

   logic         wr_en;
   logic [5:0]   wr_addr, rd_addr;
   logic [7:0]   wr_data, rd_data;
   logic [31:0]  w_word;
   logic [255:0] v_next;
   logic         shift_en;
   logic [31:0]  shift_word;
   logic [63:0]  bit_len;

   sha_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buf (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   sha_round u_round (
      .t(cnt_ff[5:0]), .w_direct(win_ff[0]), .w16(win_ff[0]), .w15(win_ff[1]),
      .w7(win_ff[9]), .w2(win_ff[14]), .v_in(v_ff), .w_out(w_word), .v_out(v_next));

   assign bit_len = {bytes_ff, 3'b000};

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; bytes_in = bytes_ff; hash_in = hash_ff;
      v_in = v_ff; pack_in = pack_ff; cnt_in = cnt_ff; first_in = first_ff;
      finish_in = finish_ff; zero_in = zero_ff; lenpad_in = lenpad_ff;
      wr_en = 1'b0; wr_addr = fill_ff; wr_data = req_payload.data_byte;
      rd_addr = cnt_ff[5:0]; shift_en = 1'b0; shift_word = w_word;
      req_stall = 1'b1; rsp_valid = 1'b0;
      rsp_payload.digest_word = hash_ff[255 - 32*cnt_ff[2:0] -: 32];
      rsp_payload.word_index = cnt_ff[2:0];
      rsp_payload.last_word = (cnt_ff[2:0] == 3'd7);
      rsp_payload.zero_digest_error = zero_ff;
      unique case (state_ff)
         ST_FILL: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (!req_payload.operation) begin
                  // store byte, count, start a block at 64
                  wr_en = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  bytes_in = bytes_ff + 61'd1;
                  if (fill_ff == 6'd63) begin
                     state_in = ST_LOAD; cnt_in = '0; finish_in = 1'b0;
                  end
               end else begin
                  // write 0x80, then zero fill from the next byte; the length fits
                  // behind the marker only when the marker lands at byte 55 or earlier
                  wr_en = 1'b1; wr_data = PAD_BYTE;
                  fill_in = fill_ff + 6'd1; finish_in = 1'b1;
                  lenpad_in = (fill_ff < LEN_START);
                  if (fill_ff == 6'd63) begin
                     // marker fills the block: compress it right away
                     state_in = ST_LOAD; cnt_in = '0;
                  end else begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            wr_en = 1'b1;
            if (lenpad_ff && fill_ff >= LEN_START) begin
               wr_data = bit_len[63 - 8*(fill_ff[2:0]) -: 8];
            end else begin
               wr_data = 8'h00;
            end
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               state_in = ST_LOAD; cnt_in = '0;
            end
         end
         ST_LOAD: begin
            // read bytes in order; rd_data is registered and arrives in the next cycle, pack into words
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff != 7'd0) begin
               pack_in = {pack_ff[23:0], rd_data};
               if (cnt_ff[1:0] == 2'd0) begin
                  shift_en = 1'b1; shift_word = {pack_ff[23:0], rd_data};
               end
            end
            if (cnt_ff == 7'd64) begin
               cnt_in = '0;
               state_in = ST_ROUND;
               v_in = first_ff ? {init_value(3'd0), init_value(3'd1), init_value(3'd2),
                  init_value(3'd3), init_value(3'd4), init_value(3'd5), init_value(3'd6),
                  init_value(3'd7)} : hash_ff;
               if (first_ff) hash_in = v_in;
               first_in = 1'b0;
            end
         end
         ST_ROUND: begin
            // words 0..15 already sit in the window in order; rotate them
            shift_en = 1'b1; v_in = v_next; cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[32*i +: 32] = hash_ff[32*i +: 32] + v_ff[32*i +: 32];
            end
            zero_in = (hash_in == '0);
            cnt_in = '0;
            if (!finish_ff) state_in = ST_FILL;
            else if (lenpad_ff) state_in = ST_EMIT;
            else begin
               // extra block: zero fill, then the length
               state_in = ST_PAD; lenpad_in = 1'b1;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  // return to a fresh message
                  state_in = ST_FILL; fill_in = '0; bytes_in = '0; first_in = 1'b1;
                  finish_in = 1'b0; cnt_in = '0;
               end
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL; fill_ff <= '0; bytes_ff <= '0; cnt_ff <= '0;
         first_ff <= 1'b1; finish_ff <= 1'b0; lenpad_ff <= 1'b0; zero_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; bytes_ff <= bytes_in; cnt_ff <= cnt_in;
         first_ff <= first_in; finish_ff <= finish_in; lenpad_ff <= lenpad_in;
         zero_ff <= zero_in;
      end
      hash_ff <= hash_in; v_ff <= v_in; pack_ff <= pack_in;
      if (shift_en) begin
         for (int i = 0; i < SCHED_DEPTH - 1; i++) win_ff[i] <= win_ff[i + 1];
         win_ff[SCHED_DEPTH - 1] <= shift_word;
      end
   end

`ifndef SYNTHESIS
   a_no_rsp_outside_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_EMIT) else $error("rsp outside emit");
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_FILL |-> req_stall) else $error("req taken while busy");
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(cnt_ff)) else $error("emit moved");
   a_fresh_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.last_word |=> first_ff && fill_ff == 6'd0)
      else $error("no restart");
`endif
endmodule
`default_nettype wire

>>> dv/tb_sha256_stream_hasher_unit.sv
// Testbench for the SHA-256 stream hasher: directed table, then random messages,
// checked word by word against a SystemVerilog digest predictor. Depends on sha_pkg.
`default_nettype none
module tb_sha256_stream_hasher_unit;
   import sha_pkg::*;

   localparam int NUM_ROWS = 20;
   localparam int STALL_LIMIT = 20000;
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   sha256_stream_hasher_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   // predictor state: one message in flight
   logic [7:0]  msg_buf [64];
   logic [5:0]  msg_fill;
   logic [60:0] msg_len;
   logic [31:0] chain [8];
   logic        at_iv;
   rsp_payload_type digest_queue [$];

   int mismatches = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   bit quiet_tail = 0;
   bit hold_rsp = 0;

   // directed rows: empty message, "abc", short messages and extremes
   typedef struct packed {
      logic        operation;
      logic [7:0]  data_byte;
      logic        has_word0;
      logic [31:0] word0;
   } dir_row_type;
   dir_row_type dir_rows [NUM_ROWS];

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // fold one 64-byte block into the chaining value
   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2, wt;
      if (at_iv) begin
         for (int i = 0; i < 8; i++) chain[i] = init_value(i[2:0]);
         at_iv = 1'b0;
      end
      for (int i = 0; i < 16; i++)
         w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            s0 = rotr(w[(t-15)&15], 7) ^ rotr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
            s1 = rotr(w[(t-2)&15], 17) ^ rotr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
            wt = w[t&15] + s0 + w[(t-7)&15] + s1;
            w[t&15] = wt;
         end
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + wt;
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   task automatic clear_message();
      msg_fill = '0;
      msg_len = '0;
      at_iv = 1'b1;
      for (int i = 0; i < 8; i++) chain[i] = init_value(i[2:0]);
   endtask

   // advance the predictor by one accepted transaction; queue digest words on finish
   task automatic predict_digest(input req_payload_type item);
      int used;
      logic [63:0] bits;
      bit all_zero;
      rsp_payload_type word;
      if (item.operation == OP_BYTE) begin
         msg_buf[msg_fill] = item.data_byte;
         msg_len = msg_len + 61'd1;
         if (msg_fill == 6'd63) begin
            compress_block();
            msg_fill = '0;
         end else begin
            msg_fill = msg_fill + 6'd1;
         end
      end else begin
         used = msg_fill;
         msg_buf[used] = PAD_BYTE;
         used++;
         if (used > 56) begin
            for (int i = used; i < 64; i++) msg_buf[i] = 8'h00;
            compress_block();
            used = 0;
         end
         for (int i = used; i < 56; i++) msg_buf[i] = 8'h00;
         bits = {msg_len, 3'b000};
         for (int i = 0; i < 8; i++) msg_buf[56+i] = bits[63-8*i -: 8];
         compress_block();
         all_zero = 1'b1;
         for (int i = 0; i < 8; i++) if (chain[i] != 0) all_zero = 1'b0;
         for (int i = 0; i < 8; i++) begin
            word.digest_word = chain[i];
            word.word_index = i[2:0];
            word.last_word = (i == 7);
            word.zero_digest_error = all_zero;
            digest_queue.push_back(word);
         end
         clear_message();
      end
   endtask

   // send one transaction, with an optional idle burst first; hold until accepted
   task automatic send_item(input req_payload_type item);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_digest(item);
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_payload_type item;
      item.operation = OP_BYTE;
      item.data_byte = b;
      send_item(item);
   endtask

   task automatic send_finish();
      req_payload_type item;
      item.operation = OP_FINISH;
      item.data_byte = 8'($urandom);
      send_item(item);
   endtask

   // random message: mostly short, sometimes across the 55/56 byte boundary
   task automatic send_message();
      int len;
      case ($urandom_range(0, 5))
         0: len = $urandom_range(0, 3);
         1: len = $urandom_range(54, 58);
         default: len = $urandom_range(0, 20);
      endcase
      for (int i = 0; i < len; i++) send_byte(8'($urandom));
      send_finish();
   endtask

   // result side: check each accepted transaction against the oldest expected word
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected digest word %h", rsp_payload);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_payload.digest_word !== want.digest_word
                || rsp_payload.word_index !== want.word_index
                || rsp_payload.last_word !== want.last_word
                || rsp_payload.zero_digest_error !== want.zero_digest_error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("digest mismatch: expected %h/%0d/%b/%b actual %h/%0d/%b/%b",
                     want.digest_word, want.word_index, want.last_word,
                     want.zero_digest_error, rsp_payload.digest_word,
                     rsp_payload.word_index, rsp_payload.last_word,
                     rsp_payload.zero_digest_error);
            end
         end
      end
   end

   // receiver stall: random bursts, one long hold-off, none in the tail
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 6) - 1) @(posedge clock);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog: count cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) timed_out = 1;
      end
   end

   initial begin
      req_payload_type item;
      int first_word_at;
      int drain;
      // directed table: empty message, "abc", short messages, extremes
      dir_rows[0] = {OP_FINISH, 8'hff, 1'b1, 32'he3b0c442};
      dir_rows[1] = {OP_BYTE, 8'h61, 1'b0, 32'h0};
      dir_rows[2] = {OP_BYTE, 8'h62, 1'b0, 32'h0};
      dir_rows[3] = {OP_BYTE, 8'h63, 1'b0, 32'h0};
      dir_rows[4] = {OP_FINISH, 8'h00, 1'b1, 32'hba7816bf};
      dir_rows[5] = {OP_BYTE, 8'h00, 1'b0, 32'h0};
      dir_rows[6] = {OP_FINISH, 8'h00, 1'b0, 32'h0};
      dir_rows[7] = {OP_BYTE, 8'hff, 1'b0, 32'h0};
      dir_rows[8] = {OP_BYTE, 8'haa, 1'b0, 32'h0};
      dir_rows[9] = {OP_BYTE, 8'h55, 1'b0, 32'h0};
      dir_rows[10] = {OP_FINISH, 8'h80, 1'b0, 32'h0};
      for (int i = 11; i < NUM_ROWS; i++) dir_rows[i] = {OP_BYTE, 8'(i * 37), 1'b0, 32'h0};
      clear_message();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NUM_ROWS; r++) begin
         first_word_at = digest_queue.size();
         item.operation = dir_rows[r].operation;
         item.data_byte = dir_rows[r].data_byte;
         send_item(item);
         // typed-in value must agree with the predictor as well
         if (dir_rows[r].has_word0
             && digest_queue[first_word_at].digest_word !== dir_rows[r].word0) begin
            mismatches++;
            if (mismatches <= 10) $display("row %0d: expected H0 %h got predicted %h", r,
               dir_rows[r].word0, digest_queue[first_word_at].digest_word);
         end
      end
      send_finish();
      // padding boundaries: marker at byte 55 (length fits), marker at byte 63
      for (int i = 0; i < 55; i++) send_byte(8'hff);
      send_finish();
      for (int i = 0; i < 63; i++) send_byte(8'($urandom));
      send_finish();

      // long receiver hold-off while the sender keeps offering
      hold_rsp = 1;
      fork
         begin
            repeat (2) send_message();
         end
         begin
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end
      join

      send_message();
      quiet_tail = 1;
      send_message();
      req_valid <= 1'b0;

      drain = 0;
      while (digest_queue.size() != 0 && !timed_out) @(posedge clock);
      while (drain < 50 && !timed_out) begin
         @(posedge clock);
         drain++;
      end
      if (!timed_out) begin
         if (mismatches == 0) $display("Test completed successfully");
         else $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      wait (timed_out);
      $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire

>>> sha256_stream_hasher_unit.f
hdl/sha_pkg.sv
hdl/sha_ram.sv
hdl/sha_round.sv
hdl/sha256_stream_hasher_unit.sv
dv/tb_sha256_stream_hasher_unit.sv
